/* rtl/byte_ring_buffer_line_extractor_core_defines.svh */
// Assertion macros used by the line extractor datapath.
`ifndef BYTE_RING_BUFFER_LINE_EXTRACTOR_CORE_DEFINES_SVH
`define BYTE_RING_BUFFER_LINE_EXTRACTOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition a must be accompanied by condition c in the same cycle.
`define BRB_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");
// Condition a must be followed by condition c in the next cycle.
`define BRB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define BRB_ASSERT_SAME(label, clk, rst, a, c)
`define BRB_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

/* rtl/brb_lx_pkg.sv */
// Package: constants, codes, types and helpers for the line extractor.
`timescale 1ns / 1ps
package brb_lx_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;
  localparam int LEN_W  = 6;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SKIP_RD,
    ST_SKIP_CHK,
    ST_LINE_RD,
    ST_LINE_CHK,
    ST_TAIL_RD,
    ST_TAIL_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_MISS
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;        // write byte at write pointer, drop oldest when full
    logic clear;       // empty the ring
    logic scan_start;  // scan pointer takes the read pointer
    logic scan_rd;     // read the store at the scan pointer
    logic scan_adv;    // step the scan pointer
    logic line_first;  // first character of the line sits at the scan pointer
    logic line_inc;    // one more character in the line
    logic emit_start;  // note the new read pointer, rewind to the line start
    logic emit_rd;     // read the store at the emit pointer
    logic emit_load;   // put one character into the output register
    logic miss_load;   // put the not-found item into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_at_end; // scan pointer has reached the write pointer
    logic rd_term;     // registered store data is CR or LF
    logic emit_last;   // the character being emitted is the final one
    logic out_free;    // output register can take an item this cycle
  } status_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    ptr_adv = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic is_term(input logic [BYTE_W-1:0] b);
    is_term = (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

/* rtl/brb_lx_ctrl.sv */
// Controller: state machine sequencing push, clear and line extraction.
`timescale 1ns / 1ps
module brb_lx_ctrl
  import brb_lx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_PUSH: begin
              cmd.push = 1'b1;
            end
            MODE_POP: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SKIP_RD;
            end
            MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SKIP_RD: begin
        if (status.scan_at_end) begin
          state_next = ST_MISS;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_SKIP_CHK;
        end
      end
      ST_SKIP_CHK: begin
        cmd.scan_adv = 1'b1;
        if (status.rd_term) begin
          state_next = ST_SKIP_RD;
        end else begin
          cmd.line_first = 1'b1;
          state_next     = ST_LINE_RD;
        end
      end
      ST_LINE_RD: begin
        if (status.scan_at_end) begin
          state_next = ST_MISS;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_LINE_CHK;
        end
      end
      ST_LINE_CHK: begin
        if (status.rd_term) begin
          cmd.scan_adv = 1'b1;
          state_next   = ST_TAIL_RD;
        end else begin
          cmd.scan_adv = 1'b1;
          cmd.line_inc = 1'b1;
          state_next   = ST_LINE_RD;
        end
      end
      ST_TAIL_RD: begin
        if (status.scan_at_end) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_RD;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_TAIL_CHK;
        end
      end
      ST_TAIL_CHK: begin
        if (status.rd_term) begin
          cmd.scan_adv = 1'b1;
          state_next   = ST_TAIL_RD;
        end else begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = status.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_MISS: begin
        if (status.out_free) begin
          cmd.miss_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/brb_lx_dp.sv */
// Datapath: byte store, ring pointers, line counters and output register.
`timescale 1ns / 1ps
`include "byte_ring_buffer_line_extractor_core_defines.svh"
module brb_lx_dp
  import brb_lx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] in_byte,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_found,
  output logic [LEN_W-1:0]  out_len
);

  logic [BYTE_W-1:0] store [DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  scan;
  logic [PTR_W-1:0]  line_start;
  logic [PTR_W-1:0]  emit_ptr;
  logic [PTR_W-1:0]  rp_after;
  logic [LEN_W-1:0]  line_len;
  logic [LEN_W-1:0]  remain;
  logic [PTR_W-1:0]  rd_addr;
  logic              rd_en;

  assign wp_next = ptr_adv(wp);
  assign rd_addr = cmd.emit_rd ? emit_ptr : scan;
  assign rd_en   = cmd.emit_rd | cmd.scan_rd;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[wp] <= in_byte;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // Ring pointers; the read pointer moves only on reset, overflow, clear or a found line.
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
    end else if (cmd.clear) begin
      rp <= '0;
      wp <= '0;
    end else if (cmd.push) begin
      wp <= wp_next;
      if (wp_next == rp) begin
        rp <= ptr_adv(rp);
      end
    end else if (cmd.emit_load && status.emit_last) begin
      rp <= rp_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan <= rp;
    end else if (cmd.scan_adv) begin
      scan <= ptr_adv(scan);
    end
    if (cmd.line_first) begin
      line_start <= scan;
      line_len   <= LEN_W'(1);
    end else if (cmd.line_inc) begin
      line_len <= line_len + 1'b1;
    end
    if (cmd.emit_start) begin
      rp_after <= scan;
      emit_ptr <= line_start;
      remain   <= line_len;
    end else if (cmd.emit_load) begin
      emit_ptr <= ptr_adv(emit_ptr);
      remain   <= remain - 1'b1;
    end
  end

  assign status.scan_at_end = (scan == wp);
  assign status.rd_term     = is_term(rdata);
  assign status.emit_last   = (remain == LEN_W'(1));
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.miss_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_byte  <= rdata;
      out_last  <= status.emit_last;
      out_found <= 1'b1;
      out_len   <= line_len;
    end else if (cmd.miss_load) begin
      out_byte  <= CH_NUL;
      out_last  <= 1'b1;
      out_found <= 1'b0;
      out_len   <= '0;
    end
  end

  `BRB_ASSERT_SAME(a_load_needs_room, clk, rst, cmd.emit_load || cmd.miss_load, status.out_free)
  `BRB_ASSERT_SAME(a_emit_count_live, clk, rst, cmd.emit_load, remain != '0)
  `BRB_ASSERT_NEXT(a_push_not_empty, clk, rst, cmd.push, rp != wp)
  `BRB_ASSERT_SAME(a_wp_in_range, clk, rst, 1'b1, wp <= PTR_LAST && rp <= PTR_LAST)

endmodule

/* rtl/byte_ring_buffer_line_extractor_core.sv */
// Top level: byte ring buffer with line extraction, stream in and stream out.
`timescale 1ns / 1ps
// Push, clear and unused codes complete in their accept cycle; the controller stays idle.
// With one store read port, a pop tests stored bytes in a read state and a check state
// each, emits each character in a read state and an output state, or gives a not-found
// item if the scan meets the write pointer before a terminator; output waits hold it.
// Reset (rst, synchronous, active high) empties the ring; store contents are not cleared.
module byte_ring_buffer_line_extractor_core
  import brb_lx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] mode, [9:2] byte_in, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] line_byte, [13:8] line_length, [15:14] zero
  output logic        m_tlast,   // last_of_line
  output logic [0:0]  m_tuser    // [0] line_found
);

  // Command and status between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;

  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] byte_in;
  logic [BYTE_W-1:0] line_byte;
  logic [LEN_W-1:0]  line_length;
  logic              line_found;

  assign mode    = s_tdata[MODE_W-1:0];
  assign byte_in = s_tdata[MODE_W+BYTE_W-1:MODE_W];

  // The controller accepts one item at a time and walks the ring for a pop.
  brb_lx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (mode),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the pointers and the output register, so a
  // finished item can wait for the consumer while the next push is taken.
  brb_lx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (byte_in),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (line_byte),
    .out_last  (m_tlast),
    .out_found (line_found),
    .out_len   (line_length)
  );

  assign m_tdata = {2'b00, line_length, line_byte};
  assign m_tuser = line_found;

endmodule
